// File: rtl/core/key_chord_action_detector_core_defines.svh
// Assertion macros for the key chord action detector core.
`ifndef KEY_CHORD_ACTION_DETECTOR_CORE_DEFINES_SVH
`define KEY_CHORD_ACTION_DETECTOR_CORE_DEFINES_SVH

`ifndef SYNTH

// pre |-> post, checked on clk, off during reset
`define KCAD_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("kcad assertion failed");

// pre |=> post, checked on clk, off during reset
`define KCAD_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("kcad assertion failed");

`else

`define KCAD_ASSERT_SAME(lbl, pre, post)
`define KCAD_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// File: rtl/core/kcad_pkg.sv
// Types and codes shared by the key chord action detector core.
`default_nettype none

package kcad_pkg;

	localparam logic [1:0] CMD_KEY  = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_TAKE = 2'd2;

	localparam logic [1:0] KEY_PWR     = 2'd0;
	localparam logic [1:0] KEY_VOLDOWN = 2'd1;
	localparam logic [1:0] KEY_SIDE    = 2'd2;

	localparam logic [1:0] VAL_RELEASE = 2'd0;
	localparam logic [1:0] VAL_PRESS   = 2'd1;
	localparam logic [1:0] VAL_REPEAT  = 2'd2;

	localparam logic [1:0] ACT_SCREENSHOT = 2'd0;
	localparam logic [1:0] ACT_BACK       = 2'd1;
	localparam logic [1:0] ACT_TOGGLE     = 2'd2;

	localparam int unsigned MS_W = 16;
	localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};
	localparam logic [MS_W-1:0] WINDOW_RESET = 16'd250;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] key_code;
		logic [1:0] key_value;
	} item_t;

	typedef struct packed {
		logic       action_valid;
		logic [1:0] action_code;
	} result_t;

	typedef struct packed {
		logic            power_held;
		logic            volume_held;
		logic            chord_used;
		logic [MS_W-1:0] power_held_ms;
		logic            pending_screenshot;
		logic            pending_back;
		logic            pending_toggle;
	} track_t;

endpackage

`default_nettype wire

// File: rtl/core/kcad_tracker.sv
// Key and chord state with the pending action flags, updated once per item.
`default_nettype none

module kcad_tracker
	import kcad_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire item_t           item,
	input  wire logic [MS_W-1:0] window,
	output result_t              result
);

	track_t st_q;
	track_t st_d;

	always_comb begin
		logic press;
		st_d = st_q;
		result = '0;
		press = (item.key_value != VAL_RELEASE);
		case (item.cmd)
			CMD_KEY: begin
				if (item.key_code == KEY_SIDE) begin
					if (item.key_value == VAL_PRESS) st_d.pending_back = 1'b1;
				end else if (item.key_code == KEY_PWR && item.key_value != VAL_REPEAT) begin
					if (press) begin
						if (!st_q.power_held) begin
							st_d.power_held = 1'b1;
							st_d.power_held_ms = '0;
						end
						if (st_q.volume_held && !st_q.chord_used) begin
							st_d.chord_used = 1'b1;
							st_d.pending_screenshot = 1'b1;
						end
					end else begin
						st_d.power_held = 1'b0;
						if (st_q.power_held && !st_q.chord_used) begin
							st_d.chord_used = 1'b1;
							st_d.pending_toggle = 1'b1;
						end
					end
				end else if (item.key_code == KEY_VOLDOWN && item.key_value != VAL_REPEAT) begin
					if (press) begin
						st_d.volume_held = 1'b1;
						if (st_q.power_held && !st_q.chord_used) begin
							st_d.chord_used = 1'b1;
							st_d.pending_screenshot = 1'b1;
						end
					end else begin
						st_d.volume_held = 1'b0;
						if (!st_q.power_held) st_d.chord_used = 1'b0;
					end
				end
			end
			CMD_TICK: begin
				if (st_q.power_held && st_q.power_held_ms != MS_MAX)
					st_d.power_held_ms = st_q.power_held_ms + 1'b1;
			end
			CMD_TAKE: begin
				// expire a long plain power press before choosing
				if (st_q.power_held && !st_q.chord_used && st_q.power_held_ms >= window) begin
					st_d.chord_used = 1'b1;
					st_d.pending_toggle = 1'b1;
				end
				if (!st_q.power_held && !st_q.volume_held) st_d.chord_used = 1'b0;
				result.action_valid = 1'b1;
				if (st_d.pending_screenshot) begin
					st_d.pending_screenshot = 1'b0;
					result.action_code = ACT_SCREENSHOT;
				end else if (st_d.pending_back) begin
					st_d.pending_back = 1'b0;
					result.action_code = ACT_BACK;
				end else if (st_d.pending_toggle) begin
					st_d.pending_toggle = 1'b0;
					result.action_code = ACT_TOGGLE;
				end else begin
					result.action_valid = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= st_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/key_chord_action_detector_core.sv
// Key chord action detector: turns key, tick and take commands into actions.
//
// Channels: s_axis (command in), m_axis (action out), cfg (chord window).
// s_tdata carries cmd, key_code and key_value; every take command yields one
// m_axis transaction with action_valid and action_code, other commands none.
// cfg_tdata writes chord_window_ms; write it only while the block is idle.
// cfg_tready is always high.
// Path: an accepted take passes the input register, then the result register
// fed by the state update logic, before it shows on m_axis.
// Throughput: one command per cycle, but a take stalls while an action waits on m_tready.
// Reset: all key state and pending actions clear, the window returns to 250,
// both channel registers empty.
// Stall: while m_tready is low a finished action holds in the result
// register; key and tick commands keep flowing, and a take waits in the
// input register, which then lowers s_tready.
`default_nettype none
`include "key_chord_action_detector_core_defines.svh"

module key_chord_action_detector_core
	import kcad_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,    // [1:0] cmd, [3:2] key_code, [5:4] key_value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,    // [0] action_valid, [2:1] action_code
	input  wire logic        cfg_tvalid,
	output logic             cfg_tready,
	input  wire logic [15:0] cfg_tdata   // [15:0] chord_window_ms
);

	logic            valid_s1;
	item_t           item_s1;
	logic            s1_adv;
	logic            s1_take;
	result_t         res;
	result_t         out_q;
	logic            out_valid_q;
	logic [MS_W-1:0] window_q;

	assign s1_take  = (item_s1.cmd == CMD_TAKE);
	// a take needs the result register free or draining
	assign s1_adv   = valid_s1 && (!s1_take || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_adv;
	assign cfg_tready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= '{cmd: s_tdata[1:0], key_code: s_tdata[3:2], key_value: s_tdata[5:4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_tvalid && cfg_tready) begin
			window_q <= cfg_tdata;
		end
	end

	kcad_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_adv),
		.item   (item_s1),
		.window (window_q),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && s1_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.action_code, out_q.action_valid};

	`KCAD_ASSERT_NEXT(a_take_makes_result, s1_adv && s1_take, m_tvalid)
	`KCAD_ASSERT_NEXT(a_take_waits, valid_s1 && s1_take && m_tvalid && !m_tready,
		valid_s1 && s1_take)
	`KCAD_ASSERT_SAME(a_no_accept_on_blocked_take,
		valid_s1 && s1_take && m_tvalid && !m_tready, !s_tready)

endmodule

`default_nettype wire

// File: verif/key_chord_action_detector_core_tb.sv
// Self-checking testbench for the key chord action detector core.
module key_chord_action_detector_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kcad_pkg::*;

	localparam logic [1:0] CMD_NONE  = 2'd3;
	localparam logic [1:0] KEY_OTHER = 2'd3;
	localparam logic [1:0] VAL_THREE = 2'd3;
	localparam result_t    NO_ACTION = '0;
	localparam int         N_PHASES  = 6;
	localparam int         N_SCRIPT  = 23;
	localparam int         DRAIN     = 8;
	localparam int         LIMIT     = 1_000_000;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] key_code;
		logic [1:0] key_value;
		bit         pinned;
		result_t    res;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_tvalid = 1'b0;
	logic        cfg_tready;
	logic [15:0] cfg_tdata = '0;

	// travels alongside s_tdata: a typed-in expectation for directed takes
	bit          pin_on = 1'b0;
	result_t     pin_res = '0;

	// predicted block state
	logic [15:0] window_ms = WINDOW_RESET;
	bit          pwr_down, vol_down, chord_spent;
	logic [15:0] pwr_ms;
	bit          want_shot, want_back, want_toggle;

	result_t     action_q[$];
	script_row_t script[N_SCRIPT];

	int send_idle_pct, recv_stall_pct;
	int errors, cycles, n_cmds, n_takes, n_shots, n_backs, n_toggles, n_empty;

	key_chord_action_detector_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),    // [1:0] cmd, [3:2] key_code, [5:4] key_value
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),    // [0] action_valid, [2:1] action_code
		.cfg_tvalid (cfg_tvalid),
		.cfg_tready (cfg_tready),
		.cfg_tdata  (cfg_tdata)   // [15:0] chord_window_ms
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout at %0d cycles, %0d outstanding", cycles, action_q.size());
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Advance the predicted state by one command; a take yields one action.
	task automatic chord_apply(input logic [1:0] cmd, code, val,
			output bit has_res, output result_t res);
		has_res = 1'b0;
		res = NO_ACTION;
		case (cmd)
			CMD_KEY: begin
				if (code == KEY_SIDE) begin
					if (val == VAL_PRESS)
						want_back = 1'b1;
				end else if (code == KEY_PWR && val != VAL_REPEAT) begin
					if (val != VAL_RELEASE) begin
						if (!pwr_down) begin
							pwr_down = 1'b1;
							pwr_ms = '0;
						end
						if (vol_down && !chord_spent) begin
							chord_spent = 1'b1;
							want_shot = 1'b1;
						end
					end else begin
						if (pwr_down && !chord_spent) begin
							chord_spent = 1'b1;
							want_toggle = 1'b1;
						end
						pwr_down = 1'b0;
					end
				end else if (code == KEY_VOLDOWN && val != VAL_REPEAT) begin
					if (val != VAL_RELEASE) begin
						vol_down = 1'b1;
						if (pwr_down && !chord_spent) begin
							chord_spent = 1'b1;
							want_shot = 1'b1;
						end
					end else begin
						vol_down = 1'b0;
						if (!pwr_down)
							chord_spent = 1'b0;
					end
				end
			end
			CMD_TICK: begin
				if (pwr_down && pwr_ms != MS_MAX)
					pwr_ms++;
			end
			CMD_TAKE: begin
				has_res = 1'b1;
				// a long power hold only turns into a toggle when checked here
				if (pwr_down && !chord_spent && pwr_ms >= window_ms) begin
					chord_spent = 1'b1;
					want_toggle = 1'b1;
				end
				if (!pwr_down && !vol_down)
					chord_spent = 1'b0;
				if (want_shot) begin
					want_shot = 1'b0;
					res = '{1'b1, ACT_SCREENSHOT};
				end else if (want_back) begin
					want_back = 1'b0;
					res = '{1'b1, ACT_BACK};
				end else if (want_toggle) begin
					want_toggle = 1'b0;
					res = '{1'b1, ACT_TOGGLE};
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		bit      has_res;
		result_t res, got, exp_res;
		if (arst_n) begin
			if (cfg_tvalid && cfg_tready)
				window_ms = cfg_tdata;
			if (m_tvalid && m_tready) begin
				got.action_valid = m_tdata[0];
				got.action_code = m_tdata[2:1];
				if (action_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected action valid=%0b code=%0d", $realtime,
							got.action_valid, got.action_code);
				end else begin
					exp_res = action_q.pop_front();
					if (got.action_valid !== exp_res.action_valid ||
							got.action_code !== exp_res.action_code) begin
						errors++;
						if (errors <= 10)
							$display("%0t: exp valid=%0b code=%0d, got valid=%0b code=%0d",
								$realtime, exp_res.action_valid, exp_res.action_code,
								got.action_valid, got.action_code);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				n_cmds++;
				chord_apply(s_tdata[1:0], s_tdata[3:2], s_tdata[5:4], has_res, res);
				if (has_res) begin
					n_takes++;
					if (pin_on)
						res = pin_res;
					if (!res.action_valid)
						n_empty++;
					else if (res.action_code == ACT_SCREENSHOT)
						n_shots++;
					else if (res.action_code == ACT_BACK)
						n_backs++;
					else
						n_toggles++;
					action_q.push_back(res);
				end
			end
		end
	end

	// Hold one command on the input channel until it is taken.
	task automatic send_cmd(input logic [1:0] cmd, code, val,
			input bit pinned = 1'b0, input result_t res = NO_ACTION);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, val, code, cmd};
		pin_on <= pinned;
		pin_res <= res;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop the input valid and let every outstanding action come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (action_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_window(input logic [15:0] w);
		cfg_tvalid <= 1'b1;
		cfg_tdata <= w;
		do @(posedge clk); while (!cfg_tready);
		cfg_tvalid <= 1'b0;
	endtask

	// Mostly real key traffic, tick runs and takes, with a little noise.
	task automatic drive_traffic(input int n);
		int sent, r, len;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(99);
			if (r < 30) begin
				if ($urandom_range(9) == 0 && window_ms <= 300)
					len = $urandom_range(1, int'(window_ms) + 20);
				else
					len = $urandom_range(1, 6);
				repeat (len) send_cmd(CMD_TICK, 2'($urandom), 2'($urandom));
				sent += len;
			end else begin
				if (r < 50)
					send_cmd(CMD_TAKE, 2'($urandom), 2'($urandom));
				else if (r < 92)
					send_cmd(CMD_KEY, 2'($urandom_range(2)), 2'($urandom_range(1)));
				else if (r < 95)
					send_cmd(CMD_NONE, 2'($urandom), 2'($urandom));
				else
					send_cmd(CMD_KEY, 2'($urandom), 2'($urandom_range(2, 3)));
				sent++;
			end
		end
	endtask

	initial begin
		int idle_tab[N_PHASES]  = '{0, 47, 0, 16, 0, 16};
		int stall_tab[N_PHASES] = '{0, 0, 47, 16, 0, 16};
		logic [15:0] w;

		script = '{
			'{CMD_TAKE, KEY_PWR,     VAL_RELEASE, 1'b1, NO_ACTION},
			'{CMD_KEY,  KEY_SIDE,    VAL_PRESS,   1'b0, NO_ACTION},
			'{CMD_TAKE, KEY_PWR,     VAL_RELEASE, 1'b1, '{1'b1, ACT_BACK}},
			'{CMD_KEY,  KEY_PWR,     VAL_PRESS,   1'b0, NO_ACTION},
			'{CMD_TICK, KEY_OTHER,   VAL_THREE,   1'b0, NO_ACTION},
			'{CMD_KEY,  KEY_VOLDOWN, VAL_PRESS,   1'b0, NO_ACTION},
			'{CMD_KEY,  KEY_PWR,     VAL_REPEAT,  1'b0, NO_ACTION},
			'{CMD_TAKE, KEY_OTHER,   VAL_THREE,   1'b1, '{1'b1, ACT_SCREENSHOT}},
			'{CMD_KEY,  KEY_PWR,     VAL_RELEASE, 1'b0, NO_ACTION},
			'{CMD_KEY,  KEY_VOLDOWN, VAL_RELEASE, 1'b0, NO_ACTION},
			'{CMD_TAKE, KEY_PWR,     VAL_RELEASE, 1'b1, NO_ACTION},
			'{CMD_KEY,  KEY_PWR,     VAL_PRESS,   1'b0, NO_ACTION},
			'{CMD_KEY,  KEY_PWR,     VAL_RELEASE, 1'b0, NO_ACTION},
			'{CMD_KEY,  KEY_OTHER,   VAL_PRESS,   1'b0, NO_ACTION},
			'{CMD_NONE, KEY_SIDE,    VAL_PRESS,   1'b0, NO_ACTION},
			'{CMD_TAKE, KEY_PWR,     VAL_RELEASE, 1'b1, '{1'b1, ACT_TOGGLE}},
			'{CMD_KEY,  KEY_SIDE,    VAL_THREE,   1'b0, NO_ACTION},
			'{CMD_KEY,  KEY_SIDE,    VAL_REPEAT,  1'b0, NO_ACTION},
			'{CMD_KEY,  KEY_VOLDOWN, VAL_THREE,   1'b0, NO_ACTION},
			'{CMD_KEY,  KEY_PWR,     VAL_THREE,   1'b0, NO_ACTION},
			'{CMD_TAKE, KEY_PWR,     VAL_RELEASE, 1'b1, '{1'b1, ACT_SCREENSHOT}},
			'{CMD_KEY,  KEY_VOLDOWN, VAL_RELEASE, 1'b0, NO_ACTION},
			'{CMD_KEY,  KEY_PWR,     VAL_RELEASE, 1'b0, NO_ACTION}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < N_PHASES; p++) begin
			send_idle_pct = idle_tab[p];
			recv_stall_pct = stall_tab[p];
			if (p == 0) begin
				foreach (script[i])
					send_cmd(script[i].cmd, script[i].key_code, script[i].key_value,
						script[i].pinned, script[i].res);
				send_cmd(CMD_TAKE, KEY_PWR, VAL_RELEASE, 1'b1, NO_ACTION);
			end else begin
				case (p)
					1: w = 16'd0;
					2: w = 16'd1;
					3: w = 16'($urandom_range(2, 60));
					4: w = MS_MAX;
					default: w = 16'($urandom_range(100, 300));
				endcase
				settle();
				write_window(w);
			end
			if (p == 4) begin
				// hold power under the widest window; the take must not expire it
				send_cmd(CMD_KEY, KEY_PWR, VAL_RELEASE);
				send_cmd(CMD_KEY, KEY_VOLDOWN, VAL_RELEASE);
				repeat (4) send_cmd(CMD_TAKE, KEY_PWR, VAL_RELEASE);
				send_cmd(CMD_KEY, KEY_PWR, VAL_PRESS);
				repeat (20) send_cmd(CMD_TICK, KEY_PWR, VAL_RELEASE);
				send_cmd(CMD_TAKE, KEY_PWR, VAL_RELEASE);
				send_cmd(CMD_KEY, KEY_PWR, VAL_RELEASE);
			end
			drive_traffic(115);
		end
		settle();
		if (action_q.size() != 0)
			errors++;

		$display("ran %0d commands over %0d window settings, %0d takes", n_cmds, N_PHASES,
			n_takes);
		$display("actions: %0d screenshot, %0d back, %0d toggle, %0d empty; %0d mismatches",
			n_shots, n_backs, n_toggles, n_empty, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/kcad_pkg.sv
rtl/core/kcad_tracker.sv
rtl/core/key_chord_action_detector_core.sv
verif/key_chord_action_detector_core_tb.sv
